[rtl/hsa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package hsa_pkg;

  localparam int DEF_SLOT_COUNT   = 256;
  localparam int DEF_HANDLE_BITS  = 24;
  localparam int DEF_PAYLOAD_BITS = 32;

  // Fixed field widths of the request and result ports.
  localparam int NODE_BITS     = 8;
  localparam int LOCAL_FIELD_W = 24;
  localparam int HANDLE_W      = NODE_BITS + LOCAL_FIELD_W;
  localparam int PAYLOAD_W     = 32;
  localparam int REQ_W         = 2;
  localparam int STATUS_W      = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_REGISTER = 2'd0,
    REQ_RETIRE   = 2'd1,
    REQ_LOOKUP   = 2'd2
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_PROBE
  } state_t;

  typedef struct packed {
    status_t              status;
    logic [HANDLE_W-1:0]  handle;
    logic [PAYLOAD_W-1:0] payload;
  } result_t;

endpackage

`default_nettype wire

[rtl/handle_slot_allocator.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake            Fields
// request   in_valid/in_ready    req_type, handle_in, payload_in
// result    out_valid/out_ready  status, handle_out, payload_out
// config    node_id_we           node_id
//
// Retire, lookup and an unknown type are accepted, then read their one slot.
// A register request probes 1 to SLOT_COUNT slots, one slot memory read per
// probe. After reset a clearing pass empties every slot of the table; no
// request is accepted during it. A result waits in the output register; the
// controller holds its finished request while that register is still full.

module handle_slot_allocator
  import hsa_pkg::*;
#(
  parameter int SLOT_COUNT   = DEF_SLOT_COUNT,
  parameter int HANDLE_BITS  = DEF_HANDLE_BITS,
  parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 node_id_we,
  input  wire logic [NODE_BITS-1:0] node_id,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [REQ_W-1:0]     req_type,
  input  wire logic [HANDLE_W-1:0]  handle_in,
  input  wire logic [PAYLOAD_W-1:0] payload_in,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [STATUS_W-1:0]       status,
  output logic [HANDLE_W-1:0]       handle_out,
  output logic [PAYLOAD_W-1:0]      payload_out
);

  localparam int SLOT_BITS = $clog2(SLOT_COUNT);
  localparam int ENTRY_W   = 1 + NODE_BITS + HANDLE_BITS + PAYLOAD_BITS;

  logic                 out_free;
  logic                 res_valid;
  result_t              res;
  result_t              out_reg;
  logic                 mem_we;
  logic [SLOT_BITS-1:0] mem_waddr;
  logic [ENTRY_W-1:0]   mem_wdata;
  logic [SLOT_BITS-1:0] mem_raddr;
  logic [ENTRY_W-1:0]   mem_rdata;

  assign out_free = !out_valid || out_ready;

  hsa_ctrl #(
    .SLOT_COUNT   (SLOT_COUNT),
    .HANDLE_BITS  (HANDLE_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .node_id_we (node_id_we),
    .node_id    (node_id),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .handle_in  (handle_in),
    .payload_in (payload_in),
    .out_free   (out_free),
    .res_valid  (res_valid),
    .res        (res),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  hsa_mem #(
    .DEPTH (SLOT_COUNT),
    .WIDTH (ENTRY_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) out_reg <= res;
  end

  assign status      = out_reg.status;
  assign handle_out  = out_reg.handle;
  assign payload_out = out_reg.payload;

endmodule

`default_nettype wire

[rtl/hsa_mem.sv]
`timescale 1ns / 1ps
`default_nettype none

module hsa_mem
  import hsa_pkg::*;
#(
  parameter int DEPTH = DEF_SLOT_COUNT,
  parameter int WIDTH = 1 + NODE_BITS + DEF_HANDLE_BITS + DEF_PAYLOAD_BITS,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/hsa_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module hsa_ctrl
  import hsa_pkg::*;
#(
  parameter int SLOT_COUNT   = DEF_SLOT_COUNT,
  parameter int HANDLE_BITS  = DEF_HANDLE_BITS,
  parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS,
  localparam int SLOT_BITS   = $clog2(SLOT_COUNT),
  localparam int ENTRY_W     = 1 + NODE_BITS + HANDLE_BITS + PAYLOAD_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 node_id_we,
  input  wire logic [NODE_BITS-1:0] node_id,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [REQ_W-1:0]     req_type,
  input  wire logic [HANDLE_W-1:0]  handle_in,
  input  wire logic [PAYLOAD_W-1:0] payload_in,
  input  wire logic                 out_free,
  output logic                      res_valid,
  output result_t                   res,
  output logic                      mem_we,
  output logic [SLOT_BITS-1:0]      mem_waddr,
  output logic [ENTRY_W-1:0]        mem_wdata,
  output logic [SLOT_BITS-1:0]      mem_raddr,
  input  wire logic [ENTRY_W-1:0]   mem_rdata
);

  // Entry layout: valid, node id, local handle, payload.
  localparam int L_LSB = PAYLOAD_BITS;
  localparam int N_LSB = PAYLOAD_BITS + HANDLE_BITS;
  localparam int V_BIT = N_LSB + NODE_BITS;
  localparam int EXT_W = (HANDLE_BITS > SLOT_BITS) ? HANDLE_BITS : SLOT_BITS;

  function automatic logic [SLOT_BITS-1:0] slot_of(input logic [HANDLE_BITS-1:0] l);
    logic [EXT_W-1:0] e;
    e = EXT_W'(l);
    return e[SLOT_BITS-1:0];
  endfunction

  state_t                  state, state_next;
  logic [NODE_BITS-1:0]    node_reg;
  logic [HANDLE_BITS-1:0]  next_index, next_index_next;
  logic [SLOT_BITS-1:0]    clr_cnt;
  logic [SLOT_BITS-1:0]    cur_slot, cur_slot_next;
  logic [SLOT_BITS-1:0]    probe_cnt, probe_cnt_next;
  logic [HANDLE_BITS-1:0]  probe_local, probe_local_next;
  req_t                    req_kind;
  logic [HANDLE_W-1:0]     req_handle;
  logic [PAYLOAD_BITS-1:0] req_payload;

  logic                    accept;
  logic                    entry_valid;
  logic [HANDLE_W-1:0]     entry_handle;
  logic                    entry_match;
  logic                    probe_last;

  assign accept       = in_valid && in_ready;
  assign entry_valid  = mem_rdata[V_BIT];
  assign entry_handle = {mem_rdata[V_BIT-1:N_LSB],
                         LOCAL_FIELD_W'(mem_rdata[N_LSB-1:L_LSB])};
  assign entry_match  = entry_valid && (entry_handle == req_handle) &&
                        (req_kind == REQ_RETIRE || req_kind == REQ_LOOKUP);
  assign probe_last   = &probe_cnt;
  assign mem_raddr    = cur_slot_next;

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (&clr_cnt) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = (req_type == REQ_REGISTER) ? ST_PROBE : ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (out_free) state_next = ST_IDLE;
      end
      ST_PROBE: begin
        if ((!entry_valid || probe_last) && out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready         = 1'b0;
    res_valid        = 1'b0;
    res.status       = STATUS_NOT_FOUND;
    res.handle       = req_handle;
    res.payload      = '0;
    mem_we           = 1'b0;
    mem_waddr        = cur_slot;
    mem_wdata        = mem_rdata;
    cur_slot_next    = cur_slot;
    probe_cnt_next   = probe_cnt;
    probe_local_next = probe_local;
    next_index_next  = next_index;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          probe_cnt_next   = '0;
          probe_local_next = next_index;
          if (req_type == REQ_REGISTER) begin
            cur_slot_next = slot_of(next_index);
          end else begin
            cur_slot_next = handle_in[SLOT_BITS-1:0];
          end
        end
      end
      ST_LOOK: begin
        if (out_free) begin
          res_valid = 1'b1;
          if (entry_match) begin
            res.status  = STATUS_OK;
            res.payload = PAYLOAD_W'(mem_rdata[L_LSB-1:0]);
            if (req_kind == REQ_RETIRE) begin
              mem_we           = 1'b1;
              mem_wdata[V_BIT] = 1'b0;
            end
          end
        end
      end
      ST_PROBE: begin
        if (!entry_valid) begin
          if (out_free) begin
            res_valid       = 1'b1;
            res.status      = STATUS_OK;
            res.handle      = {node_reg, LOCAL_FIELD_W'(probe_local)};
            mem_we          = 1'b1;
            mem_wdata       = {1'b1, node_reg, probe_local, req_payload};
            next_index_next = probe_local + 1'b1;
          end
        end else if (probe_last) begin
          if (out_free) begin
            res_valid  = 1'b1;
            res.status = STATUS_FULL;
          end
        end else begin
          // Occupied: move on to the next local handle, one slot read per cycle.
          probe_cnt_next   = probe_cnt + 1'b1;
          probe_local_next = probe_local + 1'b1;
          cur_slot_next    = slot_of(probe_local + 1'b1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_cnt    <= '0;
      next_index <= HANDLE_BITS'(1);
      node_reg   <= '0;
      cur_slot   <= '0;
    end else begin
      state      <= state_next;
      next_index <= next_index_next;
      cur_slot   <= cur_slot_next;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (node_id_we) node_reg <= node_id;
    end
  end

  always_ff @(posedge clk) begin
    probe_cnt   <= probe_cnt_next;
    probe_local <= probe_local_next;
    if (accept) begin
      req_kind    <= req_t'(req_type);
      req_handle  <= handle_in;
      req_payload <= PAYLOAD_BITS'(payload_in);
    end
  end

endmodule

`default_nettype wire

[tb/handle_slot_allocator_tb.sv]
`timescale 1ns / 1ps

module handle_slot_allocator_tb;
  import hsa_pkg::*;

  localparam int SLOTS     = DEF_SLOT_COUNT;
  localparam int LOCAL_W   = DEF_HANDLE_BITS;
  localparam int LIMIT     = 2000000;
  localparam int N_ROWS    = 24;
  localparam int HOLD_AT   = 500;
  localparam int HOLD_LEN  = 300;
  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

  typedef enum {MIX_BALANCED, MIX_FILL, MIX_DRAIN} mix_t;
  typedef enum {NOISE_RANDOM, NOISE_STALE, NOISE_ALIAS, NOISE_FOREIGN_NODE,
                NOISE_UNKNOWN_TYPE} noise_t;
  typedef enum {READY_ALWAYS, READY_RANDOM, READY_PATTERN} ready_mode_t;

  // One directed step: either a node id write or a request, with an optional
  // hand-written expectation.
  typedef struct packed {
    logic                 is_cfg;
    logic [REQ_W-1:0]     kind;
    logic [HANDLE_W-1:0]  handle;
    logic [PAYLOAD_W-1:0] tag;
    logic                 typed;
    logic [STATUS_W-1:0]  exp_status;
    logic [HANDLE_W-1:0]  exp_handle;
    logic [PAYLOAD_W-1:0] exp_tag;
  } row_t;

  logic                 clk;
  logic                 rst;
  logic                 node_id_we;
  logic [NODE_BITS-1:0] node_id;
  logic                 in_valid;
  logic                 in_ready;
  logic [REQ_W-1:0]     req_type;
  logic [HANDLE_W-1:0]  handle_in;
  logic [PAYLOAD_W-1:0] payload_in;
  logic                 out_valid;
  logic                 out_ready;
  logic [STATUS_W-1:0]  status;
  logic [HANDLE_W-1:0]  handle_out;
  logic [PAYLOAD_W-1:0] payload_out;

  // Shadow of the handle table.
  bit                   slot_busy  [SLOTS];
  logic [LOCAL_W-1:0]   slot_local [SLOTS];
  logic [PAYLOAD_W-1:0] slot_tag   [SLOTS];
  logic [NODE_BITS-1:0] slot_owner [SLOTS];
  logic [LOCAL_W-1:0]   probe_start = LOCAL_W'(1);
  logic [NODE_BITS-1:0] node_now = '0;

  result_t              outcome_fifo [$];
  logic [HANDLE_W-1:0]  live_handles [$];
  logic [HANDLE_W-1:0]  retired_handles [$];
  row_t                 directed_rows [N_ROWS];
  result_t              head_result;

  int errors = 0;
  int rx_seen = 0;
  int cycles = 0;
  int burst_left = 0;
  int gap = 0;
  int node_writes = 0;
  int req_count [4] = '{0, 0, 0, 0};
  int status_count [4] = '{0, 0, 0, 0};
  bit held_off = 0;

  handle_slot_allocator i_dut (
    .clk         (clk),
    .rst         (rst),
    .node_id_we  (node_id_we),
    .node_id     (node_id),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .handle_in   (handle_in),
    .payload_in  (payload_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .handle_out  (handle_out),
    .payload_out (payload_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic result_t table_outcome(input logic [REQ_W-1:0] kind,
                                            input logic [HANDLE_W-1:0] hin,
                                            input logic [PAYLOAD_W-1:0] tag);
    result_t            res;
    logic [LOCAL_W-1:0] loc;
    int                 s;
    int                 i;
    bit                 found;
    res.status  = STATUS_NOT_FOUND;
    res.handle  = hin;
    res.payload = '0;
    found = 0;
    if (kind == REQ_REGISTER) begin
      res.status = STATUS_FULL;
      // Probe upward from the running index; the local handle wraps at its width.
      for (i = 0; i < SLOTS; i++) begin
        if (!found) begin
          loc = probe_start + LOCAL_W'(i);
          s = int'(loc) & (SLOTS - 1);
          if (!slot_busy[s]) begin
            found         = 1;
            slot_busy[s]  = 1;
            slot_local[s] = loc;
            slot_tag[s]   = tag;
            slot_owner[s] = node_now;
            probe_start   = loc + 1'b1;
            res.status    = STATUS_OK;
            res.handle    = {node_now, loc};
          end
        end
      end
    end else if (kind == REQ_RETIRE || kind == REQ_LOOKUP) begin
      s = int'(hin) & (SLOTS - 1);
      // The stored handle keeps the node id it was issued with.
      if (slot_busy[s] && {slot_owner[s], slot_local[s]} == hin) begin
        res.status  = STATUS_OK;
        res.payload = slot_tag[s];
        if (kind == REQ_RETIRE) slot_busy[s] = 0;
      end
    end
    return res;
  endfunction

  task automatic issue_request(input logic [REQ_W-1:0] kind,
                               input logic [HANDLE_W-1:0] hin,
                               input logic [PAYLOAD_W-1:0] tag,
                               input bit typed,
                               input result_t typed_res);
    result_t res;
    int      k;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(9) < 3) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid   = 1'b1;
    req_type   = kind;
    handle_in  = hin;
    payload_in = tag;
    do @(posedge clk); while (in_ready !== 1'b1);
    res = table_outcome(kind, hin, tag);
    outcome_fifo.push_back(typed ? typed_res : res);
    req_count[kind]++;
    if (res.status == STATUS_OK && kind == REQ_REGISTER) live_handles.push_back(res.handle);
    if (res.status == STATUS_OK && kind == REQ_RETIRE) begin
      for (k = 0; k < live_handles.size(); k++) begin
        if (live_handles[k] == hin) begin
          live_handles.delete(k);
          break;
        end
      end
      retired_handles.push_back(hin);
      if (retired_handles.size() > 64) void'(retired_handles.pop_front());
    end
    burst_left--;
    // Valid stays high here; the caller either drives the next request or drops it.
    @(negedge clk);
  endtask

  task automatic write_node(input logic [NODE_BITS-1:0] value);
    in_valid = 1'b0;
    while (outcome_fifo.size() != 0) @(negedge clk);
    node_id_we = 1'b1;
    node_id    = value;
    @(posedge clk);
    node_now = value;
    @(negedge clk);
    node_id_we = 1'b0;
    node_writes++;
  endtask

  task automatic random_request(input mix_t mix, output logic [REQ_W-1:0] kind,
                                output logic [HANDLE_W-1:0] hin,
                                output logic [PAYLOAD_W-1:0] tag);
    int                  roll;
    int                  reg_cut;
    int                  ret_cut;
    int                  look_cut;
    logic [HANDLE_W-1:0] base;
    tag  = $urandom;
    hin  = $urandom;
    roll = $urandom_range(99);
    case (mix)
      MIX_FILL: begin
        reg_cut = 85; ret_cut = 85; look_cut = 95;
      end
      MIX_DRAIN: begin
        reg_cut = 15; ret_cut = 75; look_cut = 85;
      end
      default: begin
        reg_cut = 40; ret_cut = 65; look_cut = 85;
      end
    endcase
    if (roll < reg_cut) begin
      kind = REQ_REGISTER;
    end else if (roll < look_cut && live_handles.size() != 0) begin
      kind = (roll < ret_cut) ? REQ_RETIRE : REQ_LOOKUP;
      hin  = live_handles[$urandom_range(live_handles.size() - 1)];
    end else begin
      kind = $urandom_range(1) ? REQ_RETIRE : REQ_LOOKUP;
      if (live_handles.size() != 0) base = live_handles[$urandom_range(live_handles.size() - 1)];
      else base = hin;
      case (noise_t'($urandom_range(4)))
        NOISE_RANDOM: kind = REQ_W'($urandom_range(3));
        NOISE_STALE: begin
          if (retired_handles.size() != 0)
            hin = retired_handles[$urandom_range(retired_handles.size() - 1)];
        end
        // Same slot, different upper local bits.
        NOISE_ALIAS: hin = base ^ {8'h00, 16'($urandom_range(1, 65535)), 8'h00};
        NOISE_FOREIGN_NODE: hin = base ^ {8'($urandom_range(1, 255)), 24'h000000};
        default: kind = REQ_UNKNOWN;
      endcase
    end
  endtask

  task automatic run_mix(input mix_t mix, input int count);
    logic [REQ_W-1:0]     kind;
    logic [HANDLE_W-1:0]  hin;
    logic [PAYLOAD_W-1:0] tag;
    result_t              blank;
    int                   n;
    blank = '0;
    for (n = 0; n < count; n++) begin
      random_request(mix, kind, hin, tag);
      issue_request(kind, hin, tag, 1'b0, blank);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
      rx_seen++;
      if (outcome_fifo.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, status %0d handle %h payload %h",
                 $time, status, handle_out, payload_out);
      end else begin
        head_result = outcome_fifo.pop_front();
        status_count[head_result.status]++;
        if (status !== head_result.status) begin
          errors++;
          $display("%0t: status expected %0d, actual %0d", $time, head_result.status, status);
        end
        if (handle_out !== head_result.handle) begin
          errors++;
          $display("%0t: handle_out expected %h, actual %h",
                   $time, head_result.handle, handle_out);
        end
        if (payload_out !== head_result.payload) begin
          errors++;
          $display("%0t: payload_out expected %h, actual %h",
                   $time, head_result.payload, payload_out);
        end
      end
    end
  end

  initial begin : receiver
    ready_mode_t mode;
    int          stretch;
    int          period;
    int          beat;
    out_ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      stretch = $urandom_range(10, 60);
      mode    = ready_mode_t'($urandom_range(2));
      period  = $urandom_range(2, 5);
      for (beat = 0; beat < stretch; beat++) begin
        @(negedge clk);
        // One long hold-off lets the block back up into its request input.
        if (!held_off && rx_seen >= HOLD_AT) begin
          held_off  = 1;
          out_ready = 1'b0;
          repeat (HOLD_LEN) @(negedge clk);
        end
        case (mode)
          READY_ALWAYS: out_ready = 1'b1;
          READY_RANDOM: out_ready = 1'($urandom_range(1));
          default:      out_ready = (beat % period) != 0;
        endcase
      end
    end
  end

  initial begin
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("handle_slot_allocator_tb failed");
    $finish;
  end

  initial begin
    int      r;
    result_t want;
    rst        = 1'b1;
    node_id_we = 1'b0;
    node_id    = '0;
    in_valid   = 1'b0;
    req_type   = REQ_REGISTER;
    handle_in  = '0;
    payload_in = '0;
    directed_rows = '{
      '{1'b1, REQ_REGISTER, 32'h0000_0000, 32'h0000_0000, 1'b0, STATUS_OK, 32'h0, 32'h0},
      '{1'b0, REQ_REGISTER, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, STATUS_OK,
        32'h0000_0001, 32'h0000_0000},
      '{1'b0, REQ_LOOKUP, 32'h0000_0001, 32'h0000_0000, 1'b1, STATUS_OK,
        32'h0000_0001, 32'hFFFF_FFFF},
      '{1'b0, REQ_REGISTER, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, STATUS_OK,
        32'h0000_0002, 32'h0000_0000},
      '{1'b0, REQ_LOOKUP, 32'h0000_0002, 32'hFFFF_FFFF, 1'b1, STATUS_OK,
        32'h0000_0002, 32'h0000_0000},
      '{1'b0, REQ_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, STATUS_NOT_FOUND,
        32'hFFFF_FFFF, 32'h0000_0000},
      '{1'b0, REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, STATUS_NOT_FOUND,
        32'h0000_0000, 32'h0000_0000},
      '{1'b0, REQ_LOOKUP, 32'h0100_0001, 32'h0000_0000, 1'b1, STATUS_NOT_FOUND,
        32'h0100_0001, 32'h0000_0000},
      '{1'b0, REQ_LOOKUP, 32'h0000_0101, 32'h0000_0000, 1'b1, STATUS_NOT_FOUND,
        32'h0000_0101, 32'h0000_0000},
      '{1'b0, REQ_RETIRE, 32'h0000_0001, 32'h0000_0000, 1'b1, STATUS_OK,
        32'h0000_0001, 32'hFFFF_FFFF},
      '{1'b0, REQ_RETIRE, 32'h0000_0001, 32'h0000_0000, 1'b1, STATUS_NOT_FOUND,
        32'h0000_0001, 32'h0000_0000},
      '{1'b0, REQ_LOOKUP, 32'h0000_0001, 32'h0000_0000, 1'b1, STATUS_NOT_FOUND,
        32'h0000_0001, 32'h0000_0000},
      '{1'b0, REQ_REGISTER, 32'h0000_0000, 32'hA5A5_A5A5, 1'b1, STATUS_OK,
        32'h0000_0003, 32'h0000_0000},
      '{1'b0, REQ_RETIRE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, STATUS_NOT_FOUND,
        32'hFFFF_FFFF, 32'h0000_0000},
      '{1'b0, REQ_UNKNOWN, 32'h0000_0000, 32'h0000_0000, 1'b1, STATUS_NOT_FOUND,
        32'h0000_0000, 32'h0000_0000},
      '{1'b1, REQ_REGISTER, 32'h0000_0000, 32'h0000_00FF, 1'b0, STATUS_OK, 32'h0, 32'h0},
      '{1'b0, REQ_REGISTER, 32'h0000_0000, 32'h1234_5678, 1'b1, STATUS_OK,
        32'hFF00_0004, 32'h0000_0000},
      '{1'b0, REQ_LOOKUP, 32'h0000_0003, 32'h0000_0000, 1'b1, STATUS_OK,
        32'h0000_0003, 32'hA5A5_A5A5},
      '{1'b0, REQ_LOOKUP, 32'hFF00_0003, 32'h0000_0000, 1'b1, STATUS_NOT_FOUND,
        32'hFF00_0003, 32'h0000_0000},
      '{1'b0, REQ_RETIRE, 32'hFF00_0004, 32'h0000_0000, 1'b1, STATUS_OK,
        32'hFF00_0004, 32'h1234_5678},
      '{1'b0, REQ_REGISTER, 32'h0000_0000, 32'h5A5A_0F0F, 1'b0, STATUS_OK, 32'h0, 32'h0},
      '{1'b0, REQ_LOOKUP, 32'h0000_0002, 32'h0000_0000, 1'b0, STATUS_OK, 32'h0, 32'h0},
      '{1'b0, REQ_RETIRE, 32'h0000_0002, 32'h0000_0000, 1'b0, STATUS_OK, 32'h0, 32'h0},
      '{1'b0, REQ_RETIRE, 32'h0000_0003, 32'h0000_0000, 1'b0, STATUS_OK, 32'h0, 32'h0}
    };
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (r = 0; r < N_ROWS; r++) begin
      if (directed_rows[r].is_cfg) begin
        write_node(directed_rows[r].tag[NODE_BITS-1:0]);
      end else begin
        want.status  = status_t'(directed_rows[r].exp_status);
        want.handle  = directed_rows[r].exp_handle;
        want.payload = directed_rows[r].exp_tag;
        issue_request(directed_rows[r].kind, directed_rows[r].handle, directed_rows[r].tag,
                      directed_rows[r].typed, want);
      end
    end

    write_node(8'hFF);
    run_mix(MIX_BALANCED, 250);
    // Mostly registers until the table fills and reports full.
    write_node(8'($urandom_range(1, 254)));
    run_mix(MIX_FILL, 330);
    write_node(8'($urandom));
    run_mix(MIX_DRAIN, 250);
    write_node(8'h00);
    run_mix(MIX_BALANCED, 320);

    in_valid = 1'b0;
    while (outcome_fifo.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Requests sent: %0d register, %0d retire, %0d lookup, %0d unknown type;",
             req_count[REQ_REGISTER], req_count[REQ_RETIRE], req_count[REQ_LOOKUP],
             req_count[REQ_UNKNOWN]);
    $display("%0d node id writes. Results checked: %0d ok, %0d not found, %0d table full; %0d errors.",
             node_writes, status_count[STATUS_OK], status_count[STATUS_NOT_FOUND],
             status_count[STATUS_FULL], errors);
    if (errors == 0) begin
      $display("handle_slot_allocator_tb passed");
    end else begin
      $display("handle_slot_allocator_tb failed");
    end
    $finish;
  end

endmodule
